@@ src/fdp_pkg.sv @@
// Package for the fractional divider parameter calculator.
// Holds widths, constants, channel word types and state types; no dependencies.
package fdp_pkg;
    localparam int DENOM_BITS = 20;
    localparam int VCO_W = 30;
    localparam int NUM_W = 32;
    localparam int PROD_W = 62;
    localparam int IDX_W = 3;
    localparam int P1_W = 18;
    localparam int P2_W = 20;
    localparam int P3_W = 20;
    localparam logic [VCO_W-1:0] VCO_RESET = VCO_W'(800000000);
    localparam logic [NUM_W-1:0] C_APPROX = NUM_W'((64'd1 << DENOM_BITS) - 64'd1);
    localparam logic [P1_W-1:0] P1_OFFSET = P1_W'(512);

    // input word: output selector and rate fraction
    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [NUM_W-1:0] rate_numer;
        logic [NUM_W-1:0] rate_den;
    } t_rate_req;

    // result word
    typedef struct packed {
        logic [IDX_W-1:0] out_index_echo;
        logic [P1_W-1:0]  param_p1;
        logic [P2_W-1:0]  param_p2;
        logic [P3_W-1:0]  param_p3;
        logic             integer_mode;
    } t_div_params;

    // divider unit ops
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [NUM_W-1:0] divisor;
    } t_div_req;

    // gcd unit phases
    typedef enum logic [3:0] {
        G_IDLE = 4'b0001,
        G_TWOS = 4'b0010,
        G_ODDX = 4'b0100,
        G_MAIN = 4'b1000
    } t_gcd_state;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MUL    = 14'b00000000000010,
        S_DIVA   = 14'b00000000000100,
        S_GCD1   = 14'b00000000001000,
        S_RED1B  = 14'b00000000010000,
        S_RED1C  = 14'b00000000100000,
        S_APXMUL = 14'b00000001000000,
        S_APXDIV = 14'b00000010000000,
        S_GCD2   = 14'b00000100000000,
        S_RED2B  = 14'b00001000000000,
        S_RED2C  = 14'b00010000000000,
        S_P1DIV  = 14'b00100000000000,
        S_FIN    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;
endpackage

@@ src/fdp_if.sv @@
// Valid/ready channel interface carrying a payload word.
// Depends on nothing but the payload type parameter.
interface fdp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/fdp_div.sv @@
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on fdp_pkg.
module fdp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fdp_pkg::t_div_req          i_req,
    output logic                       o_done,
    output logic [63:0]                o_quot,
    output logic [fdp_pkg::NUM_W-1:0]  o_rem
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [fdp_pkg::NUM_W-1:0] r_d, n_d;
    logic [6:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [32:0] w_t;

    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_t = {r_r[31:0], r_q[63]};
        if (i_req.start) begin
            n_q = i_req.dividend; n_r = '0; n_d = i_req.divisor;
            n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_t >= {1'b0, r_d}) begin
                n_r = w_t - {1'b0, r_d};
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_r = w_t;
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[31:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 7'd63) else $error("count overrun");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start lost");
endmodule

@@ src/fdp_gcd.sv @@
// Binary GCD unit, one shift or one subtract per cycle.
// Depends on fdp_pkg.
module fdp_gcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fdp_pkg::NUM_W-1:0] i_x,
    input  logic [fdp_pkg::NUM_W-1:0] i_y,
    output logic                      o_done,
    output logic [fdp_pkg::NUM_W-1:0] o_gcd
);
    logic [fdp_pkg::NUM_W-1:0] r_x, n_x, r_y, n_y;
    logic [4:0] r_sh, n_sh;
    fdp_pkg::t_gcd_state r_ph, n_ph;
    logic r_done, n_done;

    always_comb begin
        n_x = r_x; n_y = r_y; n_sh = r_sh; n_ph = r_ph; n_done = 1'b0;
        if (i_start) begin
            n_x = i_x; n_y = i_y; n_sh = '0; n_ph = fdp_pkg::G_TWOS;
            if (i_x == '0 || i_y == '0) begin
                n_x = i_x | i_y; n_ph = fdp_pkg::G_IDLE; n_done = 1'b1;
            end
        end else begin
            case (r_ph)
                fdp_pkg::G_TWOS: begin
                    if (((r_x | r_y) & 32'd1) == '0) begin
                        n_x = r_x >> 1; n_y = r_y >> 1; n_sh = r_sh + 5'd1;
                    end else n_ph = fdp_pkg::G_ODDX;
                end
                fdp_pkg::G_ODDX: begin
                    if (!r_x[0]) n_x = r_x >> 1;
                    else n_ph = fdp_pkg::G_MAIN;
                end
                fdp_pkg::G_MAIN: begin
                    if (!r_y[0]) n_y = r_y >> 1;
                    else if (r_x > r_y) begin
                        n_x = r_y; n_y = r_x - r_y;
                        if (r_x - r_y == '0) begin
                            n_ph = fdp_pkg::G_IDLE; n_done = 1'b1;
                        end
                    end else begin
                        n_y = r_y - r_x;
                        if (r_y == r_x) begin
                            n_ph = fdp_pkg::G_IDLE; n_done = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_sh <= n_sh;
        if (!i_rst_n) begin
            r_ph <= fdp_pkg::G_IDLE; r_done <= 1'b0;
        end else begin
            r_ph <= n_ph; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_x << r_sh;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_ph == fdp_pkg::G_IDLE) else $error("done while busy");
    a_odd_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == fdp_pkg::G_MAIN && !i_start) |-> r_x[0]) else $error("x even in main loop");
    a_start_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_ph != fdp_pkg::G_IDLE || r_done)) else $error("start lost");
endmodule

@@ src/fractional_divider_params.sv @@
// Fractional divider parameter calculator: rate fraction in, P1/P2/P3 out.
// Depends on fdp_pkg, fdp_if, fdp_div, fdp_gcd.
//
// One word at a time. When the ratio is exact, the word passes through a shift-add
// product over the 30 VCO bits, then two serial 64-bit divisions (one quotient bit
// a cycle). A nonzero remainder adds a binary GCD pass (one shift or subtract a
// cycle) and two reducing divisions. A reduced denominator of 2^20 or more adds
// the S_APXMUL step, an approximating division, a second GCD pass and two more
// divisions. The serial divider dominates the run time. The input is taken only
// when the block is idle, which it enters as the result register is loaded; the
// result is held in an output register until taken, and a held result stalls the
// next word.
module fractional_divider_params (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [fdp_pkg::VCO_W-1:0] i_cfg_wdata,
    fdp_if.sink   i_in,
    fdp_if.source o_out
);
    logic [fdp_pkg::VCO_W-1:0] r_vco;
    fdp_pkg::t_state r_st, n_st;
    logic [2:0] r_idx;
    logic [31:0] r_num;
    logic [63:0] r_acc;   // product
    logic [31:0] r_mcand;
    logic [4:0]  r_mcnt;
    logic [63:0] r_a;
    logic [31:0] r_rem, r_rr, r_nn, r_g, r_b, r_c;
    logic [17:0] r_p1;
    logic [19:0] r_p2;
    logic r_ovld;
    logic [2:0]  r_oidx;
    logic [17:0] r_op1;
    logic [19:0] r_op2, r_op3;
    logic r_oint;

    fdp_pkg::t_div_req w_dreq;
    logic w_ddone;
    logic [63:0] w_quot;
    logic [31:0] w_drem;
    logic w_gstart, w_gdone;
    logic [31:0] w_gx, w_gy, w_gcd;
    logic [63:0] w_acc_nxt, w_apx;

    fdp_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_done(w_ddone),
        .o_quot(w_quot), .o_rem(w_drem));
    fdp_gcd u_gcd (.i_clk, .i_rst_n, .i_start(w_gstart), .i_x(w_gx), .i_y(w_gy),
        .o_done(w_gdone), .o_gcd(w_gcd));

    assign i_in.ready = (r_st == fdp_pkg::S_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data = {r_oidx, r_op1, r_op2, r_op3, r_oint};

    // shift-add step, one vco bit a cycle, msb first
    assign w_acc_nxt = (r_acc << 1) + (r_vco[5'd29 - r_mcnt] ? {32'd0, r_mcand} : 64'd0);
    // rr * (2^N - 1)
    assign w_apx = ({32'd0, r_rr} << fdp_pkg::DENOM_BITS) - {32'd0, r_rr};

    // b and c as they stand when the final division launches
    function automatic logic [31:0] n_b_sel();
        logic [31:0] v;
        v = r_b;
        if (r_st == fdp_pkg::S_DIVA) v = '0;
        else if (r_st == fdp_pkg::S_RED1C) v = r_rr;
        else if (r_st == fdp_pkg::S_RED2C) v = r_b;
        return v;
    endfunction
    function automatic logic [31:0] n_c_sel();
        logic [31:0] v;
        v = r_c;
        if (r_st == fdp_pkg::S_DIVA) v = 32'd1;
        else if (r_st == fdp_pkg::S_RED1C) v = w_quot[31:0];
        else if (r_st == fdp_pkg::S_RED2C) v = w_quot[31:0];
        return v;
    endfunction

    always_comb begin
        w_dreq = '0;
        w_gstart = 1'b0;
        w_gx = r_rem;
        w_gy = r_num;
        n_st = r_st;
        case (r_st)
            fdp_pkg::S_IDLE: if (i_in.valid) n_st = fdp_pkg::S_MUL;
            fdp_pkg::S_MUL: if (r_mcnt == 5'd29) begin
                n_st = fdp_pkg::S_DIVA;
            end
            fdp_pkg::S_DIVA: if (w_ddone) begin
                if (r_num == '0 || w_drem == '0) n_st = fdp_pkg::S_P1DIV;
                else n_st = fdp_pkg::S_GCD1;
            end
            fdp_pkg::S_GCD1: if (w_gdone) n_st = fdp_pkg::S_RED1B;
            fdp_pkg::S_RED1B: if (w_ddone) n_st = fdp_pkg::S_RED1C;
            fdp_pkg::S_RED1C: if (w_ddone) begin
                if (w_quot[31:fdp_pkg::DENOM_BITS] == '0) n_st = fdp_pkg::S_P1DIV;
                else n_st = fdp_pkg::S_APXMUL;
            end
            fdp_pkg::S_APXMUL: n_st = fdp_pkg::S_APXDIV;
            fdp_pkg::S_APXDIV: if (w_ddone) n_st = fdp_pkg::S_GCD2;
            fdp_pkg::S_GCD2: if (w_gdone) n_st = fdp_pkg::S_RED2B;
            fdp_pkg::S_RED2B: if (w_ddone) n_st = fdp_pkg::S_RED2C;
            fdp_pkg::S_RED2C: if (w_ddone) n_st = fdp_pkg::S_P1DIV;
            fdp_pkg::S_P1DIV: if (w_ddone) n_st = fdp_pkg::S_FIN;
            fdp_pkg::S_FIN: n_st = fdp_pkg::S_OUT;
            fdp_pkg::S_OUT: if (!r_ovld || o_out.ready) n_st = fdp_pkg::S_IDLE;
            default: n_st = fdp_pkg::S_IDLE;
        endcase
        // launch pulses on entry to each division/gcd state
        if (n_st != r_st) begin
            case (n_st)
                fdp_pkg::S_DIVA: begin
                    // product including the last shift-add step
                    w_dreq.start = 1'b1; w_dreq.dividend = w_acc_nxt;
                    w_dreq.divisor = (r_num == '0) ? 32'd1 : r_num;
                end
                fdp_pkg::S_GCD1: begin
                    w_gstart = 1'b1; w_gx = w_drem; w_gy = r_num;
                end
                fdp_pkg::S_RED1B: begin
                    w_dreq.start = 1'b1; w_dreq.dividend = {32'd0, r_rem};
                    w_dreq.divisor = w_gcd;
                end
                fdp_pkg::S_RED1C: begin
                    w_dreq.start = 1'b1; w_dreq.dividend = {32'd0, r_num};
                    w_dreq.divisor = r_g;
                end
                fdp_pkg::S_APXDIV: begin
                    w_dreq.start = 1'b1; w_dreq.dividend = w_apx;
                    w_dreq.divisor = r_nn;
                end
                fdp_pkg::S_GCD2: begin
                    w_gstart = 1'b1; w_gx = w_quot[31:0]; w_gy = fdp_pkg::C_APPROX;
                end
                fdp_pkg::S_RED2B: begin
                    w_dreq.start = 1'b1; w_dreq.dividend = {32'd0, r_b};
                    w_dreq.divisor = w_gcd;
                end
                fdp_pkg::S_RED2C: begin
                    w_dreq.start = 1'b1; w_dreq.dividend = {32'd0, fdp_pkg::C_APPROX};
                    w_dreq.divisor = r_g;
                end
                fdp_pkg::S_P1DIV: begin
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = {25'd0, n_b_sel(), 7'd0};
                    w_dreq.divisor = n_c_sel();
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            fdp_pkg::S_IDLE: if (i_in.valid) begin
                r_idx <= i_in.data.out_index;
                r_num <= i_in.data.rate_numer;
                r_mcand <= i_in.data.rate_den;
                r_acc <= '0;
                r_mcnt <= '0;
            end
            fdp_pkg::S_MUL: begin
                r_acc <= w_acc_nxt;
                r_mcnt <= r_mcnt + 5'd1;
            end
            fdp_pkg::S_DIVA: if (w_ddone) begin
                r_a <= (r_num == '0) ? 64'd0 : w_quot;
                r_rem <= (r_num == '0) ? 32'd0 : w_drem;
                r_b <= '0; r_c <= 32'd1;
            end
            fdp_pkg::S_GCD1: if (w_gdone) r_g <= w_gcd;
            fdp_pkg::S_RED1B: if (w_ddone) r_rr <= w_quot[31:0];
            fdp_pkg::S_RED1C: if (w_ddone) begin
                r_nn <= w_quot[31:0];
                r_b <= r_rr; r_c <= w_quot[31:0];
            end
            fdp_pkg::S_APXDIV: if (w_ddone) r_b <= w_quot[31:0];
            fdp_pkg::S_GCD2: if (w_gdone) r_g <= w_gcd;
            fdp_pkg::S_RED2B: if (w_ddone) r_b <= w_quot[31:0];
            fdp_pkg::S_RED2C: if (w_ddone) r_c <= w_quot[31:0];
            fdp_pkg::S_P1DIV: if (w_ddone) begin
                r_p1 <= w_quot[17:0];
                r_p2 <= w_drem[19:0];
            end
            fdp_pkg::S_FIN: r_p1 <= {r_a[10:0], 7'd0} + r_p1 - fdp_pkg::P1_OFFSET;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fdp_pkg::S_IDLE;
            r_vco <= fdp_pkg::VCO_RESET;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_vco <= i_cfg_wdata;
            if (r_st == fdp_pkg::S_OUT && (!r_ovld || o_out.ready)) begin
                r_ovld <= 1'b1;
                r_oidx <= r_idx;
                r_op1 <= r_p1;
                r_op2 <= r_p2;
                r_op3 <= r_c[19:0];
                r_oint <= !r_a[0] && (r_b == '0);
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_st == fdp_pkg::S_MUL) else $error("accept lost");
    a_c_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == fdp_pkg::S_FIN |-> r_c != '0) else $error("zero denominator");
endmodule
